FILE: rtl/weighted_moving_average_top_assert.svh
// Assertion macros for the weighted moving average block.
// Both sample on the rising edge of clock and hold off while reset is high.
`ifndef WEIGHTED_MOVING_AVERAGE_TOP_ASSERT_SVH
`define WEIGHTED_MOVING_AVERAGE_TOP_ASSERT_SVH

// Condition that holds at every edge.
`define WMA_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define WMA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/wma_pkg.sv
package wma_pkg;

   localparam int SAMPLE_W   = 32;
   localparam int SPAN_CSR_W = 7;
   localparam int QUOT_W     = 32;

   localparam logic [SPAN_CSR_W-1:0] SPAN_RESET = SPAN_CSR_W'(1);
   // largest quotient magnitude: an average of the most negative sample
   localparam logic [QUOT_W-1:0] QUOT_LIMIT = 32'h8000_0000;

   typedef struct packed {
      logic valid;
      logic neg;
   } wma_ctl_type;

endpackage

FILE: rtl/wma_window_ram.sv
module wma_window_ram #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [ADDR_W-1:0]                    wr_addr,
   input  logic signed [wma_pkg::SAMPLE_W-1:0]  wr_data,
   input  logic                                 rd_en,
   input  logic [ADDR_W-1:0]                    rd_addr,
   output logic signed [wma_pkg::SAMPLE_W-1:0]  rd_data
);
   import wma_pkg::*;

   logic signed [SAMPLE_W-1:0] mem [0:DEPTH-1];
   logic signed [SAMPLE_W-1:0] rd_data_ff;

   // read returns the old word on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/wma_accum.sv
module wma_accum #(
   parameter int MAX_SPAN = 64,
   parameter int SPAN_W   = $clog2(MAX_SPAN + 1),
   parameter int ADDR_W   = $clog2(MAX_SPAN),
   parameter int PSUM_W   = wma_pkg::SAMPLE_W + $clog2(MAX_SPAN),
   parameter int WSUM_W   = wma_pkg::SAMPLE_W + $clog2(MAX_SPAN * (MAX_SPAN + 1) / 2 + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [SPAN_W-1:0]                    eff_span,
   input  logic                                 restart,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [wma_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                 req_first,
   output logic                                 sum_valid,
   input  logic                                 sum_ready,
   output logic signed [WSUM_W-1:0]             sum_weighted
);
   import wma_pkg::*;

   logic                          accept;
   logic                          clear;
   logic                          clr_ff;
   logic [SPAN_W-1:0]             fill_ff;
   logic [SPAN_W-1:0]             fill_in;
   logic [SPAN_W-1:0]             fill_cur;
   logic [SPAN_W-1:0]             fill_inc;
   logic [ADDR_W-1:0]             wpos_ff;
   logic [ADDR_W-1:0]             wpos_in;
   logic [ADDR_W-1:0]             wpos_cur;
   logic [SPAN_W-1:0]             wpos_wide;
   logic [SPAN_W-1:0]             old_wide;
   logic [ADDR_W-1:0]             old_addr;
   logic                          full;
   logic                          emit;
   logic [SPAN_W-1:0]             weight;
   logic signed [SPAN_W:0]        weight_s;
   logic signed [SPAN_W+SAMPLE_W:0] prod_full;

   logic                          s1_valid_ff;
   logic                          s1_full_ff;
   logic                          s1_emit_ff;
   logic                          s1_clear_ff;
   logic signed [WSUM_W-1:0]      s1_prod_ff;
   logic signed [SAMPLE_W-1:0]    s1_sample_ff;
   logic signed [SAMPLE_W-1:0]    oldest;
   logic                          s1_ready;
   logic                          s1_move;
   logic                          s2_ready;

   logic                          sum_valid_ff;
   logic signed [PSUM_W-1:0]      psum_ff;
   logic signed [PSUM_W-1:0]      psum_in;
   logic signed [PSUM_W-1:0]      psum_base;
   logic signed [WSUM_W-1:0]      wsum_ff;
   logic signed [WSUM_W-1:0]      wsum_in;
   logic signed [WSUM_W-1:0]      wsum_base;

   always_comb begin
      s2_ready  = !sum_valid_ff || sum_ready;
      s1_ready  = !s1_valid_ff || s2_ready;
      req_ready = s1_ready;
      accept    = req_valid && s1_ready;
      s1_move   = s1_valid_ff && s2_ready;
   end

   // window bookkeeping at the accept edge
   always_comb begin
      clear     = req_first || clr_ff;
      fill_cur  = clear ? '0 : fill_ff;
      wpos_cur  = clear ? '0 : wpos_ff;
      full      = fill_cur >= eff_span;
      fill_inc  = fill_cur + SPAN_W'(1);
      emit      = full || (fill_inc == eff_span);
      fill_in   = full ? fill_cur : fill_inc;
      weight    = full ? eff_span : fill_inc;
      weight_s  = signed'({1'b0, weight});
      prod_full = weight_s * req_sample;
      wpos_in   = (wpos_cur == ADDR_W'(MAX_SPAN - 1)) ? '0 : wpos_cur + ADDR_W'(1);
      wpos_wide = SPAN_W'(wpos_cur);
      if (wpos_wide >= eff_span) begin
         old_wide = wpos_wide - eff_span;
      end else begin
         old_wide = wpos_wide + SPAN_W'(MAX_SPAN) - eff_span;
      end
      old_addr = old_wide[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= 1'b0;
         fill_ff <= '0;
         wpos_ff <= '0;
      end else begin
         if (restart) begin
            clr_ff <= 1'b1;
         end else if (accept) begin
            clr_ff <= 1'b0;
         end
         if (accept) begin
            fill_ff <= fill_in;
            wpos_ff <= wpos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_full_ff   <= full;
         s1_emit_ff   <= emit;
         s1_clear_ff  <= clear;
         s1_prod_ff   <= WSUM_W'(prod_full);
         s1_sample_ff <= req_sample;
      end
   end

   wma_window_ram #(
      .DEPTH  (MAX_SPAN),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wpos_cur),
      .wr_data (req_sample),
      .rd_en   (accept),
      .rd_addr (old_addr),
      .rd_data (oldest)
   );

   // W' = W - P + span*x and P' = P - oldest + x once full
   always_comb begin
      psum_base = s1_clear_ff ? '0 : psum_ff;
      wsum_base = s1_clear_ff ? '0 : wsum_ff;
      wsum_in   = wsum_base - (s1_full_ff ? WSUM_W'(psum_base) : WSUM_W'(0)) + s1_prod_ff;
      psum_in   = psum_base - (s1_full_ff ? PSUM_W'(oldest) : PSUM_W'(0))
                  + PSUM_W'(s1_sample_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         psum_ff      <= '0;
         wsum_ff      <= '0;
      end else begin
         if (s2_ready) begin
            sum_valid_ff <= s1_valid_ff && s1_emit_ff;
         end
         if (s1_move) begin
            psum_ff <= psum_in;
            wsum_ff <= wsum_in;
         end
      end
   end

   assign sum_valid    = sum_valid_ff;
   assign sum_weighted = wsum_ff;

endmodule

FILE: rtl/wma_div_cell.sv
module wma_div_cell #(
   parameter int REM_W = 44
) (
   input  logic                         clock,
   input  logic                         reset,
   input  wma_pkg::wma_ctl_type         up_ctl,
   output logic                         up_ready,
   input  logic [REM_W-1:0]             up_rem,
   input  logic [REM_W-1:0]             up_dshift,
   input  logic [wma_pkg::QUOT_W-1:0]   up_quot,
   output wma_pkg::wma_ctl_type         dn_ctl,
   input  logic                         dn_ready,
   output logic [REM_W-1:0]             dn_rem,
   output logic [REM_W-1:0]             dn_dshift,
   output logic [wma_pkg::QUOT_W-1:0]   dn_quot
);
   import wma_pkg::*;

   wma_ctl_type         ctl_ff;
   logic                take;
   logic [REM_W-1:0]    rem_ff;
   logic [REM_W-1:0]    rem_in;
   logic [REM_W-1:0]    dshift_ff;
   logic [REM_W-1:0]    dshift_in;
   logic [QUOT_W-1:0]   quot_ff;
   logic [QUOT_W-1:0]   quot_in;

   // one restoring step: subtract the shifted divisor if it fits
   always_comb begin
      up_ready  = !ctl_ff.valid || dn_ready;
      take      = up_rem >= up_dshift;
      rem_in    = take ? up_rem - up_dshift : up_rem;
      quot_in   = {up_quot[QUOT_W-2:0], take};
      dshift_in = up_dshift >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (up_ready) begin
         ctl_ff <= up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         rem_ff    <= rem_in;
         dshift_ff <= dshift_in;
         quot_ff   <= quot_in;
      end
   end

   assign dn_ctl    = ctl_ff;
   assign dn_rem    = rem_ff;
   assign dn_dshift = dshift_ff;
   assign dn_quot   = quot_ff;

endmodule

FILE: rtl/weighted_moving_average_top.sv
// Linearly weighted moving average of a stream of signed Q16.16 samples.
// Request channel (req_valid/req_ready): req_sample and req_first; a request
// with req_first high starts a new series and drops the old window.
// Response channel (rsp_valid/rsp_ready): rsp_average, the weighted average
// of the newest span samples, truncated toward zero. A request gives a
// response only once span samples of its series have arrived.
// csr_write_enable/csr_write_data set the span (0 acts as 1, values above
// MAX_SPAN act as MAX_SPAN); any write restarts the series. Write only idle.
// Throughput: one request per cycle while no stall holds the pipeline, as the
// accumulator updates its sums for each accepted request. Path to rsp_valid:
// product, sum update, sign prep, 32 divider cells, output register.
// Reset: span 1, empty window, empty pipeline; the window RAM is not
// cleared and needs no clearing pass.
// Stall: when rsp_ready is low each stage holds, empty stages close up, and
// req_ready drops only once every stage up to the input is full.
`include "weighted_moving_average_top_assert.svh"

module weighted_moving_average_top #(
   parameter int MAX_SPAN = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [wma_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                 req_first,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [wma_pkg::QUOT_W-1:0]    rsp_average,
   input  logic                                 csr_write_enable,
   input  logic [wma_pkg::SPAN_CSR_W-1:0]       csr_write_data
);
   import wma_pkg::*;

   localparam int SPAN_W = $clog2(MAX_SPAN + 1);
   localparam int ADDR_W = $clog2(MAX_SPAN);
   localparam int PSUM_W = SAMPLE_W + $clog2(MAX_SPAN);
   localparam int DIV_W  = $clog2(MAX_SPAN * (MAX_SPAN + 1) / 2 + 1);
   localparam int WSUM_W = SAMPLE_W + DIV_W;
   localparam int PAIR_W = 2 * SPAN_W + 1;
   localparam int CMP_W  = (SPAN_W > SPAN_CSR_W) ? SPAN_W : SPAN_CSR_W;
   localparam int NCELL  = QUOT_W;

   logic [SPAN_CSR_W-1:0]    span_ff;
   logic [CMP_W-1:0]         span_wide;
   logic [SPAN_W-1:0]        eff_span;
   logic [SPAN_W:0]          span_plus;
   logic [PAIR_W-1:0]        span_pair;
   logic [DIV_W-1:0]         divisor_ff;
   logic [DIV_W-1:0]         divisor_in;

   logic                     sum_valid;
   logic signed [WSUM_W-1:0] sum_weighted;

   wma_ctl_type              prep_ctl_ff;
   logic                     prep_ready;
   logic [WSUM_W-1:0]        prep_rem_ff;
   logic [WSUM_W-1:0]        prep_rem_in;
   logic [WSUM_W-1:0]        prep_dshift_ff;

   wma_ctl_type              ctl_chain    [0:NCELL];
   logic                     ready_chain  [0:NCELL];
   logic [WSUM_W-1:0]        rem_chain    [0:NCELL];
   logic [WSUM_W-1:0]        dshift_chain [0:NCELL];
   logic [QUOT_W-1:0]        quot_chain   [0:NCELL];

   logic                     out_ready;
   logic                     rsp_valid_ff;
   logic signed [QUOT_W-1:0] rsp_average_ff;
   logic signed [QUOT_W-1:0] average_in;

   // Span register; a write also restarts the series in the accumulator.
   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff <= SPAN_RESET;
      end else if (csr_write_enable) begin
         span_ff <= csr_write_data;
      end
   end

   // Clamp the span into 1..MAX_SPAN.
   always_comb begin
      span_wide = CMP_W'(span_ff);
      if (span_ff == '0) begin
         eff_span = SPAN_W'(1);
      end else if (span_wide > CMP_W'(MAX_SPAN)) begin
         eff_span = SPAN_W'(MAX_SPAN);
      end else begin
         eff_span = SPAN_W'(span_wide);
      end
   end

   // Divisor span*(span+1)/2, registered; it settles long before a weighted
   // sum of the new span reaches the divider.
   always_comb begin
      span_plus  = {1'b0, eff_span} + (SPAN_W + 1)'(1);
      span_pair  = PAIR_W'(eff_span) * PAIR_W'(span_plus);
      divisor_in = DIV_W'(span_pair >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff <= DIV_W'(1);
      end else begin
         divisor_ff <= divisor_in;
      end
   end

   wma_accum #(
      .MAX_SPAN (MAX_SPAN),
      .SPAN_W   (SPAN_W),
      .ADDR_W   (ADDR_W),
      .PSUM_W   (PSUM_W),
      .WSUM_W   (WSUM_W)
   ) u_accum (
      .clock        (clock),
      .reset        (reset),
      .eff_span     (eff_span),
      .restart      (csr_write_enable),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_sample   (req_sample),
      .req_first    (req_first),
      .sum_valid    (sum_valid),
      .sum_ready    (prep_ready),
      .sum_weighted (sum_weighted)
   );

   // Sign prep: split the weighted sum into sign and magnitude, and line the
   // divisor up with the top quotient bit.
   always_comb begin
      prep_ready  = !prep_ctl_ff.valid || ready_chain[0];
      prep_rem_in = sum_weighted[WSUM_W-1] ? WSUM_W'(-sum_weighted) : WSUM_W'(sum_weighted);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ctl_ff <= '0;
      end else if (prep_ready) begin
         prep_ctl_ff <= '{valid: sum_valid, neg: sum_weighted[WSUM_W-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (prep_ready) begin
         prep_rem_ff    <= prep_rem_in;
         prep_dshift_ff <= WSUM_W'(divisor_ff) << (QUOT_W - 1);
      end
   end

   assign ctl_chain[0]    = prep_ctl_ff;
   assign rem_chain[0]    = prep_rem_ff;
   assign dshift_chain[0] = prep_dshift_ff;
   assign quot_chain[0]   = '0;

   // Divider row: each cell settles one quotient bit, most significant first,
   // and hands remainder, shifted divisor and partial quotient to the next.
   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      wma_div_cell #(
         .REM_W (WSUM_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .up_ctl    (ctl_chain[k]),
         .up_ready  (ready_chain[k]),
         .up_rem    (rem_chain[k]),
         .up_dshift (dshift_chain[k]),
         .up_quot   (quot_chain[k]),
         .dn_ctl    (ctl_chain[k+1]),
         .dn_ready  (ready_chain[k+1]),
         .dn_rem    (rem_chain[k+1]),
         .dn_dshift (dshift_chain[k+1]),
         .dn_quot   (quot_chain[k+1])
      );
   end

   // Output register: restore the sign, which truncates toward zero.
   always_comb begin
      out_ready  = !rsp_valid_ff || rsp_ready;
      average_in = ctl_chain[NCELL].neg ? signed'(-quot_chain[NCELL])
                                        : signed'(quot_chain[NCELL]);
   end

   assign ready_chain[NCELL] = out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= ctl_chain[NCELL].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_average_ff <= average_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;

   // A zero divisor would mean the span clamp is broken.
   `WMA_ASSERT_ALWAYS(a_divisor_nonzero, divisor_ff != '0, "divisor register is zero")
   // The average lies within the sample range, so the magnitude fits.
   `WMA_ASSERT_ALWAYS(a_quot_range,
      !ctl_chain[NCELL].valid || quot_chain[NCELL] <= QUOT_LIMIT, "quotient out of range")
   // Hold a finished quotient while the output register is blocked.
   `WMA_ASSERT_NEXT(a_last_cell_hold, ctl_chain[NCELL].valid && !out_ready,
      ctl_chain[NCELL].valid, "last cell dropped a result")
   // Hold the prepared operand while the first cell is blocked.
   `WMA_ASSERT_NEXT(a_prep_hold, prep_ctl_ff.valid && !ready_chain[0],
      prep_ctl_ff.valid, "prep stage dropped a request")

endmodule
